>>> rtl/imucrc_pkg.sv
// ----------------------------------------------------------------------------
// imucrc_pkg
// Widths, CRC constants and the tables that describe the word-wide CRC update
// of the burst frame checker.
// ----------------------------------------------------------------------------
package imucrc_pkg;

  localparam int WORD_W = 16;
  localparam int IDX_W  = 4;
  localparam int OUT_W  = 1 + 3 * WORD_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;

  typedef logic [WORD_W-1:0] crc_col_t [WORD_W];

  // Bit-serial reference update over one word, low byte first, each byte
  // taken from its least significant bit. Only used to build the tables.
  function automatic logic [WORD_W-1:0] fold_word_serial(
    input logic [WORD_W-1:0] crc_in,
    input logic [WORD_W-1:0] data_in
  );
    logic [WORD_W-1:0] crc;
    crc = crc_in;
    for (int k = 0; k < WORD_W; k++) begin
      if ((crc[0] ^ data_in[k]) == 1'b1) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // The update is linear, so each register bit and each data bit has a fixed
  // contribution to the next register value.
  function automatic crc_col_t crc_columns(input logic data_side);
    crc_col_t cols;
    for (int i = 0; i < WORD_W; i++) begin
      if (data_side) begin
        cols[i] = fold_word_serial('0, WORD_W'(1) << i);
      end else begin
        cols[i] = fold_word_serial(WORD_W'(1) << i, '0);
      end
    end
    return cols;
  endfunction

endpackage

>>> rtl/imu_burst_crc_checker.sv
// ----------------------------------------------------------------------------
// imu_burst_crc_checker
// Counts the words of a sensor burst frame, folds the measurement words into
// a 16-bit CRC and reports one result per frame with pass or fail.
// ----------------------------------------------------------------------------
// Usage: words enter on the s_ channel, one request per 16-bit word, with
// s_tuser high on the status word that opens a frame. A frame is FRAME_WORDS
// words: status, measurements, then the received CRC. The counter also runs
// freely, so a frame without a start flag is still framed from reset or from
// the end of the previous frame; a start flag mid-frame drops the partial
// frame silently.
// One request leaves on the m_ channel per completed frame, after the CRC
// word passes the input and result registers. The block accepts a word in
// every cycle unless a CRC word waits: the input register is processed
// by a combinational word-wide CRC update, and the result register decouples
// the receiver. When the receiver stalls with a result pending, status and
// measurement words still flow; only the next CRC word waits in the input
// register until the result is taken. Reset clears the counter to the status
// word position, loads the CRC with all ones and empties both registers.
// ----------------------------------------------------------------------------
module imu_burst_crc_checker #(
  parameter int FRAME_WORDS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // burst_word[15:0]
  input  logic        s_tuser,  // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_ok[0], computed_crc[16:1], received_crc[32:17], diag_status[48:33]
  output logic [imucrc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int W   = imucrc_pkg::WORD_W;
  localparam int IW  = imucrc_pkg::IDX_W;
  localparam logic [IW:0]   FW_EXT   = (IW + 1)'(FRAME_WORDS);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_WORDS - 1);
  localparam imucrc_pkg::crc_col_t CRC_COL = imucrc_pkg::crc_columns(1'b0);
  localparam imucrc_pkg::crc_col_t DAT_COL = imucrc_pkg::crc_columns(1'b1);

  logic          in_valid;
  logic [W-1:0]  in_word;
  logic          in_start;

  logic [IW-1:0] word_index;
  logic [W-1:0]  crc_accumulator;
  logic [W-1:0]  status_hold;

  logic          out_valid;
  logic          out_ok;
  logic [W-1:0]  out_calc;
  logic [W-1:0]  out_recv;
  logic [W-1:0]  out_status;

  logic [IW-1:0] idx;
  logic          is_head;
  logic          is_last;
  logic          proc_fire;
  logic [W-1:0]  crc_fold;
  logic [W-1:0]  crc_inv;
  logic [W-1:0]  crc_calc;

  always_comb begin
    if ({1'b0, word_index} < FW_EXT) begin
      idx = word_index;
    end else begin
      idx = '0;
    end
    is_head = in_start || (idx == '0);
    is_last = !is_head && (idx == LAST_IDX);
    proc_fire = in_valid && (!is_last || !out_valid || m_tready);
    crc_fold = '0;
    for (int i = 0; i < W; i++) begin
      if (crc_accumulator[i]) begin
        crc_fold = crc_fold ^ CRC_COL[i];
      end
      if (in_word[i]) begin
        crc_fold = crc_fold ^ DAT_COL[i];
      end
    end
    crc_inv  = ~crc_accumulator;
    crc_calc = {crc_inv[7:0], crc_inv[15:8]};
  end

  assign s_tready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      word_index      <= '0;
      crc_accumulator <= imucrc_pkg::CRC_INIT;
      status_hold     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_word  <= s_tdata;
        in_start <= s_tuser;
      end else if (proc_fire) begin
        in_valid <= 1'b0;
      end

      if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (proc_fire) begin
        if (is_head) begin
          status_hold     <= in_word;
          crc_accumulator <= imucrc_pkg::CRC_INIT;
          word_index      <= IW'(1);
        end else if (is_last) begin
          out_valid       <= 1'b1;
          out_ok          <= (crc_calc == in_word);
          out_calc        <= crc_calc;
          out_recv        <= in_word;
          out_status      <= status_hold;
          crc_accumulator <= imucrc_pkg::CRC_INIT;
          word_index      <= '0;
        end else begin
          crc_accumulator <= crc_fold;
          word_index      <= idx + IW'(1);
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = imucrc_pkg::OUT_TDATA_W'({out_status, out_recv, out_calc, out_ok});

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, word_index} < FW_EXT)
    else $error("word counter left the frame");

  a_ok_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ok == (out_calc == out_recv)))
    else $error("pass flag disagrees with the CRC pair");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && is_last) |=> (out_valid && word_index == '0
      && crc_accumulator == imucrc_pkg::CRC_INIT))
    else $error("frame end did not post a result and restart");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !(proc_fire && is_last))
    else $error("pending result overwritten");

  a_head_restarts: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && is_head) |=> (word_index == IW'(1)
      && crc_accumulator == imucrc_pkg::CRC_INIT))
    else $error("status word did not restart the frame");

endmodule
